// File: sv/ksbc_pkg.sv
// Package with shared types and constants for the key speed-step brake controller.
`default_nettype none
package ksbc_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [RegIdxW-1:0] REG_START_SPEED    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_STEP_SPEED     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_SPEED      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LOCK_TIME      = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HOLD_THRESHOLD = 3'd4;

  localparam logic [9:0]  START_SPEED_RST    = 10'd30;
  localparam logic [9:0]  STEP_SPEED_RST     = 10'd10;
  localparam logic [9:0]  MAX_SPEED_RST      = 10'd200;
  localparam logic [15:0] LOCK_TIME_RST      = 16'd250;
  localparam logic [14:0] HOLD_THRESHOLD_RST = 15'd10;

  // Absolute ceiling for the target clamp.
  localparam logic [9:0] TARGET_LIMIT = 10'd1000;

  // Phase codes as reported on the result channel.
  localparam logic [1:0] PHASE_CODE_POWERON = 2'd0;
  localparam logic [1:0] PHASE_CODE_RUN     = 2'd1;
  localparam logic [1:0] PHASE_CODE_WAIT    = 2'd2;

  typedef enum logic [2:0] {
    PH_POWERON = 3'b001,
    PH_RUN     = 3'b010,
    PH_WAIT    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [9:0]  start_speed;
    logic [9:0]  step_speed;
    logic [9:0]  max_speed;
    logic [15:0] lock_time;
    logic [14:0] hold_threshold;
  } cfg_t;

  typedef struct packed {
    logic               up_pressed;
    logic               down_pressed;
    logic               drive_ready;
    logic signed [15:0] measured_speed;
    logic               ms_tick;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] target_speed;
    logic               hold_mode;
    logic               ramp_enable;
    logic               ramp_reset;
    logic               capture_angle;
    logic [1:0]         phase;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/ksbc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface ksbc_in_if;
  logic               valid;
  logic               ready;
  logic               up_pressed;
  logic               down_pressed;
  logic               drive_ready;
  logic signed [15:0] measured_speed;
  logic               ms_tick;

  modport source (output valid, output up_pressed, output down_pressed, output drive_ready,
                  output measured_speed, output ms_tick, input ready);
  modport sink   (input valid, input up_pressed, input down_pressed, input drive_ready,
                  input measured_speed, input ms_tick, output ready);
endinterface

interface ksbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] target_speed;
  logic               hold_mode;
  logic               ramp_enable;
  logic               ramp_reset;
  logic               capture_angle;
  logic [1:0]         phase;

  modport source (output valid, output target_speed, output hold_mode, output ramp_enable,
                  output ramp_reset, output capture_angle, output phase, input ready);
  modport sink   (input valid, input target_speed, input hold_mode, input ramp_enable,
                  input ramp_reset, input capture_angle, input phase, output ready);
endinterface
`default_nettype wire

// File: sv/ksbc_cfg.sv
// APB-style configuration register file for the controller settings.
`default_nettype none
module ksbc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ksbc_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [ksbc_pkg::CfgDataW-1:0]    pwdata,
  output      logic [ksbc_pkg::CfgDataW-1:0]    prdata,
  output      logic                             pready,
  output      ksbc_pkg::cfg_t                   cfg
);

  ksbc_pkg::cfg_t                    cfg_r;
  logic                              wr_en;
  logic [ksbc_pkg::RegIdxW-1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ksbc_pkg::CfgAddrW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_speed    <= ksbc_pkg::START_SPEED_RST;
      cfg_r.step_speed     <= ksbc_pkg::STEP_SPEED_RST;
      cfg_r.max_speed      <= ksbc_pkg::MAX_SPEED_RST;
      cfg_r.lock_time      <= ksbc_pkg::LOCK_TIME_RST;
      cfg_r.hold_threshold <= ksbc_pkg::HOLD_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ksbc_pkg::REG_START_SPEED:    cfg_r.start_speed    <= pwdata[9:0];
        ksbc_pkg::REG_STEP_SPEED:     cfg_r.step_speed     <= pwdata[9:0];
        ksbc_pkg::REG_MAX_SPEED:      cfg_r.max_speed      <= pwdata[9:0];
        ksbc_pkg::REG_LOCK_TIME:      cfg_r.lock_time      <= pwdata[15:0];
        ksbc_pkg::REG_HOLD_THRESHOLD: cfg_r.hold_threshold <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ksbc_pkg::REG_START_SPEED:    prdata = {22'd0, cfg_r.start_speed};
      ksbc_pkg::REG_STEP_SPEED:     prdata = {22'd0, cfg_r.step_speed};
      ksbc_pkg::REG_MAX_SPEED:      prdata = {22'd0, cfg_r.max_speed};
      ksbc_pkg::REG_LOCK_TIME:      prdata = {16'd0, cfg_r.lock_time};
      ksbc_pkg::REG_HOLD_THRESHOLD: prdata = {17'd0, cfg_r.hold_threshold};
      default:                      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/ksbc_core.sv
// Controller state and the single-pass step logic that turns one item into one result.
`default_nettype none
module ksbc_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire ksbc_pkg::cfg_t      cfg,
  input  wire ksbc_pkg::in_item_t  item,
  output      ksbc_pkg::out_item_t result
);

  ksbc_pkg::phase_t   phase_r, phase_nxt;
  logic signed [10:0] target_r, target_nxt;
  logic               brake_r, brake_nxt;
  logic               ramp_r, ramp_nxt;
  logic               hold_r, hold_nxt;
  logic [15:0]        lock_r, lock_nxt;

  logic [16:0]        speed_mag;
  logic               hold_fire;
  logic [9:0]         limit;
  logic signed [11:0] lim_s;
  logic signed [11:0] step_base;
  logic signed [11:0] step_val;
  logic signed [11:0] step_clamped;
  logic               up_only;
  logic               prst;
  logic               do_brake;
  logic               do_step;
  logic [15:0]        lock_mid;
  logic [1:0]         phase_code;

  always_comb begin
    speed_mag = item.measured_speed[15] ? 17'(-$signed({item.measured_speed[15],
                                                        item.measured_speed}))
                                        : {1'b0, item.measured_speed};
    hold_fire = brake_r && (speed_mag <= {2'b00, cfg.hold_threshold});
    limit     = (cfg.max_speed > ksbc_pkg::TARGET_LIMIT) ? ksbc_pkg::TARGET_LIMIT
                                                         : cfg.max_speed;
    lim_s     = $signed({2'b00, limit});
  end

  // Pending-brake check runs first; the phase action sees its updated flags.
  always_comb begin
    phase_nxt  = phase_r;
    target_nxt = target_r;
    brake_nxt  = hold_fire ? 1'b0 : brake_r;
    hold_nxt   = hold_r | hold_fire;
    ramp_nxt   = ramp_r | hold_fire;
    prst       = hold_fire;
    lock_mid   = lock_r;
    do_brake   = 1'b0;
    do_step    = 1'b0;
    up_only    = item.up_pressed;

    unique case (phase_r)
      ksbc_pkg::PH_POWERON: begin
        if (item.drive_ready) begin
          ramp_nxt   = 1'b0;
          target_nxt = '0;
          phase_nxt  = ksbc_pkg::PH_RUN;
        end
      end
      ksbc_pkg::PH_RUN: begin
        do_brake = item.up_pressed & item.down_pressed;
        do_step  = item.up_pressed ^ item.down_pressed;
      end
      ksbc_pkg::PH_WAIT: begin
        if (lock_r == '0) begin
          if (!item.up_pressed && !item.down_pressed) begin
            phase_nxt = ksbc_pkg::PH_RUN;
          end
          do_brake = item.up_pressed & item.down_pressed;
        end
      end
      default: ;
    endcase

    // From a stopped ramp the key picks the sign of the start speed.
    if (target_r == '0 && !ramp_nxt) begin
      step_base = up_only ? $signed({2'b00, cfg.start_speed})
                          : -$signed({2'b00, cfg.start_speed});
      step_val  = step_base;
    end else begin
      step_base = {target_r[10], target_r};
      step_val  = up_only ? step_base + $signed({2'b00, cfg.step_speed})
                          : step_base - $signed({2'b00, cfg.step_speed});
    end
    if (step_val > lim_s) begin
      step_clamped = lim_s;
    end else if (step_val < -lim_s) begin
      step_clamped = -lim_s;
    end else begin
      step_clamped = step_val;
    end

    if (do_brake) begin
      target_nxt = '0;
      hold_nxt   = 1'b0;
      prst       = 1'b1;
      ramp_nxt   = 1'b1;
      brake_nxt  = 1'b1;
      lock_mid   = cfg.lock_time;
      phase_nxt  = ksbc_pkg::PH_WAIT;
    end else if (do_step) begin
      prst       = prst | ~ramp_nxt;
      brake_nxt  = 1'b0;
      target_nxt = step_clamped[10:0];
      hold_nxt   = 1'b0;
      ramp_nxt   = 1'b1;
      lock_mid   = cfg.lock_time;
      phase_nxt  = ksbc_pkg::PH_WAIT;
    end

    lock_nxt = (item.ms_tick && lock_mid != '0) ? lock_mid - 16'd1 : lock_mid;
  end

  always_comb begin
    unique case (phase_nxt)
      ksbc_pkg::PH_POWERON: phase_code = ksbc_pkg::PHASE_CODE_POWERON;
      ksbc_pkg::PH_RUN:     phase_code = ksbc_pkg::PHASE_CODE_RUN;
      ksbc_pkg::PH_WAIT:    phase_code = ksbc_pkg::PHASE_CODE_WAIT;
      default:              phase_code = ksbc_pkg::PHASE_CODE_POWERON;
    endcase
    result.target_speed  = target_nxt;
    result.hold_mode     = hold_nxt;
    result.ramp_enable   = ramp_nxt;
    result.ramp_reset    = prst;
    result.capture_angle = hold_fire;
    result.phase         = phase_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ksbc_pkg::PH_POWERON;
      target_r <= '0;
      brake_r  <= 1'b0;
      ramp_r   <= 1'b0;
      hold_r   <= 1'b0;
      lock_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      target_r <= target_nxt;
      brake_r  <= brake_nxt;
      ramp_r   <= ramp_nxt;
      hold_r   <= hold_nxt;
      lock_r   <= lock_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/key_speed_step_brake_control_top.sv
// Key speed-step brake controller: input register, step logic and result register.
//
// Each input item is one control call: two key levels, a drive-ready flag, the
// measured speed and a millisecond tick. Each item yields exactly one result item
// with the target speed, hold mode, ramp flags, capture pulse and phase.
// Channels are valid/ready; an item moves when valid and ready are both high.
// An accepted item lands in the input register; when it advances, the step logic
// updates the controller state and loads the result register, which offers the
// result. The block takes one item per cycle as long as the receiver keeps
// ready high; the result register and the input register are each one item deep.
// When the receiver stalls, the result holds and the input register keeps its
// item, and in_ch.ready drops once both are full.
// Reset (rst_n low, synchronous) empties both registers, puts the controller in
// the power-on phase with a zero target, and loads the register defaults.
// Settings are written over the APB-style port at byte address 4 * index; the user
// must write them only while no item is in flight: the block does not enforce it.
`default_nettype none
module key_speed_step_brake_control_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ksbc_in_if.sink                            in_ch,
  ksbc_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ksbc_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [ksbc_pkg::CfgDataW-1:0] pwdata,
  output      logic [ksbc_pkg::CfgDataW-1:0] prdata,
  output      logic                          pready
);

  ksbc_pkg::cfg_t      cfg;
  ksbc_pkg::in_item_t  in_item_r;
  ksbc_pkg::out_item_t result;
  ksbc_pkg::out_item_t out_item_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;
  logic                in_take;

  assign advance      = in_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~in_valid_r | advance;
  assign in_take      = in_ch.valid & in_ch.ready;

  ksbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ksbc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cfg     (cfg),
    .item    (in_item_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.up_pressed     <= in_ch.up_pressed;
      in_item_r.down_pressed   <= in_ch.down_pressed;
      in_item_r.drive_ready    <= in_ch.drive_ready;
      in_item_r.measured_speed <= in_ch.measured_speed;
      in_item_r.ms_tick        <= in_ch.ms_tick;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.target_speed  = out_item_r.target_speed;
  assign out_ch.hold_mode     = out_item_r.hold_mode;
  assign out_ch.ramp_enable   = out_item_r.ramp_enable;
  assign out_ch.ramp_reset    = out_item_r.ramp_reset;
  assign out_ch.capture_angle = out_item_r.capture_angle;
  assign out_ch.phase         = out_item_r.phase;

endmodule
`default_nettype wire
